>>> rtl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types, constants and the key classification for the RF remote
// pulse decoder.
// ----------------------------------------------------------------------------
package rpd_pkg;

   localparam int CODE_BITS   = 16;
   localparam int CNT_W       = $clog2(CODE_BITS + 1);
   localparam int WIDTH_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_WIDTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_WIDTH       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_WIDTH      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_TOLERANCE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_TOLERANCE    = 3'd4;

   localparam logic [WIDTH_W-1:0] RST_HEADER_WIDTH     = 16'd11400;
   localparam logic [WIDTH_W-1:0] RST_LONG_WIDTH       = 16'd3000;
   localparam logic [WIDTH_W-1:0] RST_SHORT_WIDTH      = 16'd1000;
   localparam logic [WIDTH_W-1:0] RST_HEADER_TOLERANCE = 16'd900;
   localparam logic [WIDTH_W-1:0] RST_BIT_TOLERANCE    = 16'd200;

   typedef logic [2:0] key_type;

   localparam key_type KEY_NONE  = 3'd0;
   localparam key_type KEY_UP    = 3'd1;
   localparam key_type KEY_DOWN  = 3'd2;
   localparam key_type KEY_LEFT  = 3'd3;
   localparam key_type KEY_RIGHT = 3'd4;
   localparam key_type KEY_MENU  = 3'd5;

   // Lower bounds are excluded from each range.
   localparam logic [CODE_BITS-1:0] MENU_LO  = 16'h69C0;
   localparam logic [CODE_BITS-1:0] MENU_HI  = 16'h69DF;
   localparam logic [CODE_BITS-1:0] LEFT_LO  = 16'h69A0;
   localparam logic [CODE_BITS-1:0] LEFT_HI  = 16'h69BF;
   localparam logic [CODE_BITS-1:0] RIGHT_LO = 16'h6960;
   localparam logic [CODE_BITS-1:0] RIGHT_HI = 16'h697F;
   localparam logic [CODE_BITS-1:0] UP_LO    = 16'h6920;
   localparam logic [CODE_BITS-1:0] UP_HI    = 16'h693F;
   localparam logic [CODE_BITS-1:0] DOWN_LO  = 16'h6940;
   localparam logic [CODE_BITS-1:0] DOWN_HI  = 16'h695F;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DATA = 2'd1,
      PH_END  = 2'd2
   } phase_type;

   typedef struct packed {
      logic hdr;
      logic one;
      logic zero;
   } class_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      key_type              key;
   } result_type;

   function automatic key_type key_of(input logic [CODE_BITS-1:0] c);
      key_type k;
      k = KEY_NONE;
      if (c inside {[MENU_LO + 16'd1 : MENU_HI]}) begin
         k = KEY_MENU;
      end else if (c inside {[LEFT_LO + 16'd1 : LEFT_HI]}) begin
         k = KEY_LEFT;
      end else if (c inside {[RIGHT_LO + 16'd1 : RIGHT_HI]}) begin
         k = KEY_RIGHT;
      end else if (c inside {[UP_LO + 16'd1 : UP_HI]}) begin
         k = KEY_UP;
      end else if (c inside {[DOWN_LO + 16'd1 : DOWN_HI]}) begin
         k = KEY_DOWN;
      end
      return k;
   endfunction

endpackage

>>> rtl/rpd_fifo.sv
// ----------------------------------------------------------------------------
// rpd_fifo
// Small register queue; a push is taken while full if a pop happens too.
// ----------------------------------------------------------------------------
module rpd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rpd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_pop  = pop && !empty;
   assign do_push = push && (!full || do_pop);
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/rpd_front.sv
// ----------------------------------------------------------------------------
// rpd_front
// Holds the width and tolerance registers and classifies each pulse as a
// header, a one bit or a zero bit.
// ----------------------------------------------------------------------------
module rpd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rpd_pkg::WIDTH_W-1:0]        csr_data,
   input  logic                               req_push,
   input  logic [rpd_pkg::WIDTH_W-1:0]        req_pulse_us,
   input  logic                               cls_full,
   output logic                               cls_push,
   output rpd_pkg::class_type                 cls_data
);

   logic [rpd_pkg::WIDTH_W-1:0] header_width_ff;
   logic [rpd_pkg::WIDTH_W-1:0] long_width_ff;
   logic [rpd_pkg::WIDTH_W-1:0] short_width_ff;
   logic [rpd_pkg::WIDTH_W-1:0] header_tolerance_ff;
   logic [rpd_pkg::WIDTH_W-1:0] bit_tolerance_ff;

   function automatic logic near_width(input logic [rpd_pkg::WIDTH_W-1:0] v,
                                       input logic [rpd_pkg::WIDTH_W-1:0] nominal,
                                       input logic [rpd_pkg::WIDTH_W-1:0] tol);
      logic [rpd_pkg::WIDTH_W-1:0] d;
      d = (v >= nominal) ? (v - nominal) : (nominal - v);
      return (d <= tol);
   endfunction

   assign csr_ready = 1'b1;
   assign cls_push  = req_push && !cls_full;

   always_comb begin
      cls_data.hdr  = near_width(req_pulse_us, header_width_ff, header_tolerance_ff);
      cls_data.one  = near_width(req_pulse_us, long_width_ff, bit_tolerance_ff);
      cls_data.zero = near_width(req_pulse_us, short_width_ff, bit_tolerance_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_width_ff     <= rpd_pkg::RST_HEADER_WIDTH;
         long_width_ff       <= rpd_pkg::RST_LONG_WIDTH;
         short_width_ff      <= rpd_pkg::RST_SHORT_WIDTH;
         header_tolerance_ff <= rpd_pkg::RST_HEADER_TOLERANCE;
         bit_tolerance_ff    <= rpd_pkg::RST_BIT_TOLERANCE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rpd_pkg::CSR_HEADER_WIDTH:     header_width_ff     <= csr_data;
            rpd_pkg::CSR_LONG_WIDTH:       long_width_ff       <= csr_data;
            rpd_pkg::CSR_SHORT_WIDTH:      short_width_ff      <= csr_data;
            rpd_pkg::CSR_HEADER_TOLERANCE: header_tolerance_ff <= csr_data;
            rpd_pkg::CSR_BIT_TOLERANCE:    bit_tolerance_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule

>>> rtl/rpd_back.sv
// ----------------------------------------------------------------------------
// rpd_back
// Frame state machine: collects bits, confirms the frame on a trailing
// header and emits each new code with its key class.
// ----------------------------------------------------------------------------
module rpd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cls_empty,
   input  rpd_pkg::class_type   cls_data,
   output logic                 cls_pop,
   input  logic                 rsp_space,
   output logic                 res_push,
   output rpd_pkg::result_type  res_data
);

   rpd_pkg::phase_type phase_ff, phase_in;
   logic [rpd_pkg::CODE_BITS-1:0] shift_ff, shift_in;
   logic [rpd_pkg::CODE_BITS-1:0] last_ff, last_in;
   logic [rpd_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [rpd_pkg::CNT_W-1:0]     count_plus;
   logic                          go;
   logic                          bit_ok;

   assign go         = !cls_empty && rsp_space;
   assign cls_pop    = go;
   assign bit_ok     = cls_data.one || cls_data.zero;
   assign count_plus = count_ff + rpd_pkg::CNT_W'(1);

   always_comb begin
      phase_in = phase_ff;
      if (go) begin
         case (phase_ff)
            rpd_pkg::PH_DATA: begin
               if (!bit_ok) begin
                  phase_in = rpd_pkg::PH_IDLE;
               end else if (count_plus == rpd_pkg::CNT_W'(rpd_pkg::CODE_BITS)) begin
                  phase_in = rpd_pkg::PH_END;
               end
            end
            rpd_pkg::PH_END: phase_in = rpd_pkg::PH_IDLE;
            default: phase_in = cls_data.hdr ? rpd_pkg::PH_DATA : rpd_pkg::PH_IDLE;
         endcase
      end
   end

   always_comb begin
      shift_in      = shift_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      res_push      = 1'b0;
      res_data.code = shift_ff;
      res_data.key  = rpd_pkg::key_of(shift_ff);
      if (go) begin
         case (phase_ff)
            rpd_pkg::PH_DATA: begin
               shift_in = {shift_ff[rpd_pkg::CODE_BITS-2:0], cls_data.one};
               count_in = bit_ok ? count_plus : '0;
            end
            rpd_pkg::PH_END: begin
               count_in = '0;
               if (cls_data.hdr && (shift_ff != last_ff)) begin
                  last_in  = shift_ff;
                  res_push = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rpd_pkg::PH_IDLE;
         shift_ff <= '0;
         count_ff <= '0;
         last_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

endmodule

>>> rtl/rf_remote_pulse_decoder_unit.sv
// ----------------------------------------------------------------------------
// rf_remote_pulse_decoder_unit
// Pulse width decoder for an RF remote: classifies pulses, assembles 16-bit
// frames and reports each newly confirmed code with its key class.
//
//   Channel   Ports                              Beat taken when
//   request   req_push, req_full, req_pulse_us   req_push && !req_full
//   response  rsp_pop, rsp_empty, rsp_code/key   rsp_pop && !rsp_empty
//   config    csr_valid, csr_ready, index/data   csr_valid && csr_ready
//
// One pulse is accepted per cycle while req_full is low; the front classifies
// it in the cycle it arrives, and the back runs the frame state machine on it
// once it leaves the class queue, and only while the response queue has room.
// The two-entry queues between front, back and response let either side
// stall on its own; req_full rises only when the class queue fills.
// Reset is synchronous and restores the register defaults and idle state.
// ----------------------------------------------------------------------------
module rf_remote_pulse_decoder_unit #(
   parameter int QUEUE_DEPTH = rpd_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [rpd_pkg::WIDTH_W-1:0]     req_pulse_us,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [rpd_pkg::CODE_BITS-1:0]   rsp_code,
   output rpd_pkg::key_type                rsp_key,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rpd_pkg::WIDTH_W-1:0]     csr_data
);

   localparam int CLS_W = $bits(rpd_pkg::class_type);
   localparam int RES_W = $bits(rpd_pkg::result_type);

   rpd_pkg::class_type  cls_wdata;
   rpd_pkg::class_type  cls_rdata;
   rpd_pkg::result_type res_wdata;
   rpd_pkg::result_type res_rdata;
   logic                cls_push_w;
   logic                cls_full_w;
   logic                cls_pop_w;
   logic                cls_empty_w;
   logic                res_push_w;
   logic                res_full_w;
   logic                rsp_space_w;

   rpd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_push     (req_push),
      .req_pulse_us (req_pulse_us),
      .cls_full     (cls_full_w),
      .cls_push     (cls_push_w),
      .cls_data     (cls_wdata)
   );

   rpd_fifo #(
      .WIDTH (CLS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cls_queue (
      .clock (clock),
      .reset (reset),
      .push  (cls_push_w),
      .wdata (cls_wdata),
      .full  (cls_full_w),
      .pop   (cls_pop_w),
      .rdata (cls_rdata),
      .empty (cls_empty_w)
   );

   assign req_full    = cls_full_w;
   assign rsp_space_w = !res_full_w || rsp_pop;

   rpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_empty (cls_empty_w),
      .cls_data  (cls_rdata),
      .cls_pop   (cls_pop_w),
      .rsp_space (rsp_space_w),
      .res_push  (res_push_w),
      .res_data  (res_wdata)
   );

   rpd_fifo #(
      .WIDTH (RES_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push_w),
      .wdata (res_wdata),
      .full  (res_full_w),
      .pop   (rsp_pop),
      .rdata (res_rdata),
      .empty (rsp_empty)
   );

   assign rsp_code = res_rdata.code;
   assign rsp_key  = res_rdata.key;

`ifndef SYNTHESIS
   a_res_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push_w |-> (!res_full_w || (rsp_pop && !rsp_empty)))
      else $error("result beat pushed into a full response queue");

   a_cls_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cls_push_w |-> !cls_full_w)
      else $error("pulse pushed into a full class queue");

   a_back_waits: assert property (@(posedge clock) disable iff (reset)
      cls_pop_w |-> !cls_empty_w)
      else $error("back end consumed from an empty class queue");

   a_reset_clears: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (rsp_empty && !req_full))
      else $error("queues not cleared by reset");
`endif

endmodule
